// ===== src/fgal_pkg.sv =====
// Package for the glyph address lookup block: sizes, header constants,
// register indexes, shared structs and the glyph size function.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package fgal_pkg;

   // Block table depth and derived widths.
   localparam int MAX_BLOCKS = 128;
   localparam int TBL_AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

   // Field widths.
   localparam int CODE_W = 16;
   localparam int DIM_W  = 6;
   localparam int OFS_W  = 24;
   localparam int BC_W   = 8;
   localparam int BYTE_W = 8;
   localparam int SIZE_W = 10;
   localparam int HDR_W  = 11;

   // Font image layout.
   localparam int SB_LIMIT  = 256;
   localparam int SB_HEADER = 17;
   localparam int DB_HEADER = 18;

   // Opcodes of an input item.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH  = 3'd0,
      CSR_HALF_HEIGHT = 3'd1,
      CSR_FULL_WIDTH  = 3'd2,
      CSR_FULL_HEIGHT = 3'd3,
      CSR_BLOCK_COUNT = 3'd4
   } csr_index_type;

   localparam logic [DIM_W-1:0] HALF_WIDTH_RST  = 6'd8;
   localparam logic [DIM_W-1:0] HALF_HEIGHT_RST = 6'd16;
   localparam logic [DIM_W-1:0] FULL_WIDTH_RST  = 6'd16;
   localparam logic [DIM_W-1:0] FULL_HEIGHT_RST = 6'd16;
   localparam logic [BC_W-1:0]  BLOCK_COUNT_RST = 8'd0;

   // Configuration register set as seen by the engine.
   typedef struct packed {
      logic [DIM_W-1:0] half_width;
      logic [DIM_W-1:0] half_height;
      logic [DIM_W-1:0] full_width;
      logic [DIM_W-1:0] full_height;
      logic [BC_W-1:0]  block_count;
   } cfg_type;

   // Access to the block table.
   typedef struct packed {
      logic              wr_en;
      logic [TBL_AW-1:0] wr_addr;
      logic [CODE_W-1:0] wr_start;
      logic [CODE_W-1:0] wr_end;
      logic              rd_en;
      logic [TBL_AW-1:0] rd_addr;
   } tbl_req_type;

   // Bytes in one glyph: whole bytes per row times rows.
   function automatic logic [SIZE_W-1:0] glyph_size(input logic [DIM_W-1:0] w,
                                                    input logic [DIM_W-1:0] h);
      logic [DIM_W:0] wpad;
      logic [3:0]     row_bytes;
      wpad      = {1'b0, w} + 7'd7;
      row_bytes = wpad[DIM_W:3];
      return {6'd0, row_bytes} * {4'd0, h};
   endfunction

endpackage

`default_nettype wire

// ===== src/fontx_glyph_address_lookup.sv =====
// Top level of the glyph address lookup: configuration registers, block
// table and lookup engine. Depends on fgal_pkg, fgal_table and fgal_engine.
//
// Usage:
//   The req channel takes one item per handshake. A load item (opcode 0)
//   writes range_start and range_end into table slot entry_index and
//   leaves the sequencer idle; it produces no result. A lookup item
//   (opcode 1) produces exactly one rsp item with the glyph's byte
//   offset and dimensions. A code below 0x100 goes from acceptance to
//   rsp_valid through one multiply, one add and one output load. Any
//   other code walks the block table from slot 0, one table read per
//   cycle through the single read port, over at most 128 entries; a hit
//   then takes the same multiply, add and load; a miss only the load.
//   req_ready is high only while the sequencer is idle.
//   The csr channel is always ready and may be written only when the block
//   is idle. Reset restores the register defaults (8x16 single-byte glyphs,
//   16x16 double-byte glyphs, no blocks); the table is not cleared and must
//   be loaded before lookups rely on it. The result is held in an output
//   register: while rsp_ready is low a new item can still be accepted, and
//   its result waits in the sequencer until the register is free.
`default_nettype none

module fontx_glyph_address_lookup
   import fgal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [6:0]            req_entry_index,
   input  wire logic [CODE_W-1:0]     req_range_start,
   input  wire logic [CODE_W-1:0]     req_range_end,
   input  wire logic [CODE_W-1:0]     req_char_code,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_found,
   output logic                       rsp_double_byte,
   output logic [OFS_W-1:0]           rsp_byte_offset,
   output logic [DIM_W-1:0]           rsp_glyph_width,
   output logic [DIM_W-1:0]           rsp_glyph_height,
   output logic [BYTE_W-1:0]          rsp_glyph_bytes,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   tbl_req_type       tbl_req;
   logic [CODE_W-1:0] tbl_start;
   logic [CODE_W-1:0] tbl_end;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:  cfg_in.half_width  = csr_wdata[DIM_W-1:0];
            CSR_HALF_HEIGHT: cfg_in.half_height = csr_wdata[DIM_W-1:0];
            CSR_FULL_WIDTH:  cfg_in.full_width  = csr_wdata[DIM_W-1:0];
            CSR_FULL_HEIGHT: cfg_in.full_height = csr_wdata[DIM_W-1:0];
            CSR_BLOCK_COUNT: cfg_in.block_count = csr_wdata[BC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_width  <= HALF_WIDTH_RST;
         cfg_ff.half_height <= HALF_HEIGHT_RST;
         cfg_ff.full_width  <= FULL_WIDTH_RST;
         cfg_ff.full_height <= FULL_HEIGHT_RST;
         cfg_ff.block_count <= BLOCK_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Block table.
   fgal_table u_table (
      .clock    (clock),
      .tbl_req  (tbl_req),
      .rd_start (tbl_start),
      .rd_end   (tbl_end)
   );

   // Lookup sequencer with the shared multiplier.
   fgal_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .req_char_code    (req_char_code),
      .tbl_req          (tbl_req),
      .tbl_start        (tbl_start),
      .tbl_end          (tbl_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_double_byte  (rsp_double_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_glyph_width  (rsp_glyph_width),
      .rsp_glyph_height (rsp_glyph_height),
      .rsp_glyph_bytes  (rsp_glyph_bytes)
   );

`ifndef SYNTH
   // A load completes in the cycle it is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_LOAD)) |=> req_ready)
      else $error("load item did not leave the block ready");

   // A lookup keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_LOOKUP)) |=> !req_ready)
      else $error("lookup item did not occupy the sequencer");

   // Single-byte codes always hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_double_byte) |-> rsp_found)
      else $error("single-byte result reported a miss");

   // A miss carries a zero offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_byte_offset == '0))
      else $error("miss result carries a non-zero offset");
`endif

endmodule

`default_nettype wire

// ===== src/fgal_table.sv =====
// Block table memory: one write port and one registered read port.
// Depends on fgal_pkg for the table depth and access struct.
`default_nettype none

module fgal_table
   import fgal_pkg::*;
(
   input  wire logic              clock,
   input  wire tbl_req_type       tbl_req,
   output logic [CODE_W-1:0]      rd_start,
   output logic [CODE_W-1:0]      rd_end
);

   logic [2*CODE_W-1:0] table_mem_ff [MAX_BLOCKS];
   logic [2*CODE_W-1:0] rd_data_ff;

   // Write a range on a load item.
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         table_mem_ff[tbl_req.wr_addr] <= {tbl_req.wr_start, tbl_req.wr_end};
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= table_mem_ff[tbl_req.rd_addr];
      end
   end

   assign rd_start = rd_data_ff[2*CODE_W-1:CODE_W];
   assign rd_end   = rd_data_ff[CODE_W-1:0];

endmodule

`default_nettype wire

// ===== src/fgal_engine.sv =====
// Lookup sequencer: walks the block table one entry a cycle for double-byte
// codes, runs the shared multiplier and header add, and holds the result.
// Depends on fgal_pkg; drives the fgal_table access struct.
`default_nettype none

module fgal_engine
   import fgal_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_opcode,
   input  wire logic [6:0]        req_entry_index,
   input  wire logic [CODE_W-1:0] req_range_start,
   input  wire logic [CODE_W-1:0] req_range_end,
   input  wire logic [CODE_W-1:0] req_char_code,
   output tbl_req_type            tbl_req,
   input  wire logic [CODE_W-1:0] tbl_start,
   input  wire logic [CODE_W-1:0] tbl_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_found,
   output logic                   rsp_double_byte,
   output logic [OFS_W-1:0]       rsp_byte_offset,
   output logic [DIM_W-1:0]       rsp_glyph_width,
   output logic [DIM_W-1:0]       rsp_glyph_height,
   output logic [BYTE_W-1:0]      rsp_glyph_bytes
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;

   logic [CODE_W-1:0] code_ff, code_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [DIM_W-1:0]  w_ff, w_in;
   logic [DIM_W-1:0]  h_ff, h_in;
   logic              dbl_ff, dbl_in;
   logic              found_ff, found_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [OFS_W-1:0]  idx_ff, idx_in;
   logic [OFS_W-1:0]  sum_ff, sum_in;
   logic [OFS_W-1:0]  prod_ff, prod_in;
   logic [OFS_W-1:0]  ofs_ff, ofs_in;

   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_dbl_ff, rsp_dbl_in;
   logic [OFS_W-1:0]     rsp_ofs_ff, rsp_ofs_in;
   logic [DIM_W-1:0]     rsp_w_ff, rsp_w_in;
   logic [DIM_W-1:0]     rsp_h_ff, rsp_h_in;
   logic [BYTE_W-1:0]    rsp_bytes_ff, rsp_bytes_in;

   logic                 accept;
   logic                 hit;
   logic                 remaining;
   logic [OFS_W+SIZE_W-1:0] mul_full;
   logic [SIZE_W-1:0]    half_size;
   logic [SIZE_W-1:0]    full_size;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign half_size = glyph_size(cfg.half_width, cfg.half_height);
   assign full_size = glyph_size(cfg.full_width, cfg.full_height);

   // Compare the entry read last cycle against the code.
   assign hit       = pend_ff && (code_ff >= tbl_start) && (code_ff <= tbl_end);
   assign remaining = (cnt_ff != walk_ff);

   // Shared multiplier: glyph index times glyph size, kept modulo 2^24.
   assign mul_full = {{SIZE_W{1'b0}}, idx_ff} * {{OFS_W{1'b0}}, size_ff};

   // Table access: loads write in the idle state, the walk reads.
   always_comb begin
      tbl_req          = '0;
      tbl_req.wr_en    = accept && (req_opcode == OP_LOAD)
                         && (32'(req_entry_index) < MAX_BLOCKS);
      tbl_req.wr_addr  = TBL_AW'(req_entry_index);
      tbl_req.wr_start = req_range_start;
      tbl_req.wr_end   = req_range_end;
      tbl_req.rd_en    = (state_ff == ST_WALK) && !hit && remaining;
      tbl_req.rd_addr  = cnt_ff[TBL_AW-1:0];
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      walk_in      = walk_ff;
      code_in      = code_ff;
      size_in      = size_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      dbl_in       = dbl_ff;
      found_in     = found_ff;
      hdr_in       = hdr_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      ofs_in       = ofs_ff;
      rsp_found_in = rsp_found_ff;
      rsp_dbl_in   = rsp_dbl_ff;
      rsp_ofs_in   = rsp_ofs_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_bytes_in = rsp_bytes_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_LOOKUP)) begin
               code_in  = req_char_code;
               found_in = 1'b1;
               if (req_char_code < CODE_W'(SB_LIMIT)) begin
                  // Single-byte font: no walk needed.
                  size_in  = half_size;
                  w_in     = cfg.half_width;
                  h_in     = cfg.half_height;
                  dbl_in   = 1'b0;
                  hdr_in   = HDR_W'(SB_HEADER);
                  idx_in   = OFS_W'(req_char_code);
                  state_in = ST_MUL;
               end else begin
                  size_in  = full_size;
                  w_in     = cfg.full_width;
                  h_in     = cfg.full_height;
                  dbl_in   = 1'b1;
                  hdr_in   = HDR_W'(DB_HEADER) + HDR_W'({cfg.block_count, 2'b00});
                  sum_in   = '0;
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  if (32'(cfg.block_count) > MAX_BLOCKS) begin
                     walk_in = CNT_W'(MAX_BLOCKS);
                  end else begin
                     walk_in = CNT_W'(cfg.block_count);
                  end
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (hit) begin
               idx_in   = sum_ff + OFS_W'(code_ff) - OFS_W'(tbl_start);
               pend_in  = 1'b0;
               state_in = ST_MUL;
            end else begin
               // Earlier ranges add their length, wrapping like the offset.
               if (pend_ff) begin
                  sum_in = sum_ff + OFS_W'(tbl_end) - OFS_W'(tbl_start) + OFS_W'(1);
               end
               pend_in = remaining;
               if (remaining) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (!pend_ff && !remaining) begin
                  found_in = 1'b0;
                  ofs_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_full[OFS_W-1:0];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            ofs_in   = prod_ff + OFS_W'(hdr_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait for the output register to be free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_dbl_in   = dbl_ff;
               rsp_ofs_in   = ofs_ff;
               rsp_w_in     = w_ff;
               rsp_h_in     = h_ff;
               rsp_bytes_in = (size_ff > SIZE_W'(255)) ? 8'hFF : size_ff[BYTE_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         walk_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         walk_ff      <= walk_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      size_ff      <= size_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      dbl_ff       <= dbl_in;
      found_ff     <= found_in;
      hdr_ff       <= hdr_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      ofs_ff       <= ofs_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dbl_ff   <= rsp_dbl_in;
      rsp_ofs_ff   <= rsp_ofs_in;
      rsp_w_ff     <= rsp_w_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_double_byte  = rsp_dbl_ff;
   assign rsp_byte_offset  = rsp_ofs_ff;
   assign rsp_glyph_width  = rsp_w_ff;
   assign rsp_glyph_height = rsp_h_ff;
   assign rsp_glyph_bytes  = rsp_bytes_ff;

endmodule

`default_nettype wire
